FILE: hdl/calendar_date_info_defines.svh
// Assertion macros for the calendar date info block.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef CALENDAR_DATE_INFO_DEFINES_SVH
`define CALENDAR_DATE_INFO_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CDI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("calendar_date_info: check failed");

// next-cycle implication, disabled while in reset
`define CDI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("calendar_date_info: check failed");

`endif

FILE: hdl/cdi_pkg.sv
// Shared types, register codes and calendar tables for the calendar date info block.
// No dependencies.
package cdi_pkg;

    localparam logic REG_WEEKEND_MASK = 1'b0;
    localparam logic REG_WEEK_END_DAY = 1'b1;

    localparam int CFG_WIDTH = 7;
    localparam logic [2:0] WEEKDAY_INVALID = 3'd7;

    // floor(y / 100) = (y * 5243) >> 19, exact for y below 16384
    localparam int RECIP100 = 5243;
    localparam int SHIFT100 = 19;
    // floor(s / 7) = (s * 9363) >> 16, exact for s below 13110
    localparam int RECIP7 = 9363;
    localparam int SHIFT7 = 16;

    typedef struct packed {
        logic [6:0] weekend_mask;
        logic [2:0] week_end_day;
    } cfg_t;

    // first member ends up in the highest bits
    typedef struct packed {
        logic       date_invalid;
        logic [8:0] days_to_year_end;
        logic [4:0] days_to_month_end;
        logic [2:0] days_to_week_end;
        logic       is_business_day;
        logic       is_weekend;
        logic       is_week_end_day;
        logic [2:0] weekday;
    } res_t;

    function automatic logic [4:0] month_len_f(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before_f(input logic [3:0] month);
        logic [8:0] n;
        case (month)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // (31 * m) / 12 with m the March-based month number
    function automatic logic [4:0] month_term_f(input logic [3:0] month);
        logic [4:0] t;
        case (month)
            4'd3:    t = 5'd2;
            4'd4:    t = 5'd5;
            4'd5:    t = 5'd7;
            4'd6:    t = 5'd10;
            4'd7:    t = 5'd12;
            4'd8:    t = 5'd15;
            4'd9:    t = 5'd18;
            4'd10:   t = 5'd20;
            4'd11:   t = 5'd23;
            4'd12:   t = 5'd25;
            4'd1:    t = 5'd28;
            4'd2:    t = 5'd31;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

FILE: hdl/cdi_core.sv
// Four-stage date pipeline: divide, sum and leap, modulo seven, week flags.
// Depends on cdi_pkg and calendar_date_info_defines.svh.
`include "calendar_date_info_defines.svh"

module cdi_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [4:0]    in_day,
    input  logic [3:0]    in_month,
    input  logic [13:0]   in_year,
    input  cdi_pkg::cfg_t cfg,
    output logic          out_valid,
    input  logic          out_ready,
    output cdi_pkg::res_t out_res
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !v4_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign v1_next = rdy1 ? in_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;
    assign v4_next = rdy4 ? v3_reg : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // stage 1: shifted year and divisions by 100
    logic        early;
    logic [13:0] y_shift;
    logic [26:0] prod_y, prod_yr;
    logic [4:0]  s1_day_reg;
    logic [3:0]  s1_month_reg;
    logic [13:0] s1_year_reg, s1_y_reg;
    logic [7:0]  s1_qy_reg, s1_qyr_reg;
    logic        s1_bad_reg;

    assign early   = (in_month <= 4'd2);
    assign y_shift = in_year - {13'd0, early};
    assign prod_y  = 27'(y_shift) * 27'(cdi_pkg::RECIP100);
    assign prod_yr = 27'(in_year) * 27'(cdi_pkg::RECIP100);

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_day_reg   <= in_day;
            s1_month_reg <= in_month;
            s1_year_reg  <= in_year;
            s1_y_reg     <= y_shift;
            s1_qy_reg    <= prod_y[cdi_pkg::SHIFT100 +: 8];
            s1_qyr_reg   <= prod_yr[cdi_pkg::SHIFT100 +: 8];
            s1_bad_reg   <= (in_month == 4'd0) || (in_month > 4'd12) || (in_year == 14'd0)
                            || (in_year > 14'd9999) || (in_day == 5'd0);
        end
    end

    // stage 2: leap rule, month length, day of year, weekday sum
    logic [13:0] hundreds;
    logic        div100, leap;
    logic [4:0]  mlen;
    logic [14:0] sum;
    logic [8:0]  doy;
    logic [14:0] s2_sum_reg;
    logic [4:0]  s2_mlen_reg, s2_day_reg;
    logic [8:0]  s2_doy_reg;
    logic        s2_leap_reg, s2_bad_reg;

    assign hundreds = 14'({6'd0, s1_qyr_reg} * 14'd100);
    assign div100   = (hundreds == s1_year_reg);
    assign leap     = ((s1_year_reg[1:0] == 2'd0) && !div100)
                      || (div100 && (s1_qyr_reg[1:0] == 2'd0));
    assign mlen     = cdi_pkg::month_len_f(s1_month_reg)
                      + {4'd0, leap && (s1_month_reg == 4'd2)};
    assign doy      = cdi_pkg::days_before_f(s1_month_reg) + {4'd0, s1_day_reg}
                      + {8'd0, leap && (s1_month_reg > 4'd2)};
    assign sum      = {1'b0, s1_y_reg} + {3'd0, s1_y_reg[13:2]} - {7'd0, s1_qy_reg}
                      + {9'd0, s1_qy_reg[7:2]} + {10'd0, s1_day_reg}
                      + {10'd0, cdi_pkg::month_term_f(s1_month_reg)};

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_sum_reg  <= sum;
            s2_mlen_reg <= mlen;
            s2_day_reg  <= s1_day_reg;
            s2_doy_reg  <= doy;
            s2_leap_reg <= leap;
            s2_bad_reg  <= s1_bad_reg || (s1_day_reg > mlen);
        end
    end

    // stage 3: weekday by reciprocal, remaining day counts
    logic [28:0] prod7;
    logic [12:0] q7;
    logic [14:0] rem7;
    logic [2:0]  s3_wd_reg;
    logic [4:0]  s3_dme_reg;
    logic [8:0]  s3_dye_reg;
    logic        s3_bad_reg;

    assign prod7 = 29'(s2_sum_reg) * 29'(cdi_pkg::RECIP7);
    assign q7    = prod7[cdi_pkg::SHIFT7 +: 13];
    assign rem7  = s2_sum_reg - {q7[11:0], 3'd0} + {2'd0, q7};

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_wd_reg  <= rem7[2:0];
            s3_dme_reg <= s2_mlen_reg - s2_day_reg + 5'd1;
            s3_dye_reg <= (s2_leap_reg ? 9'd367 : 9'd366) - s2_doy_reg;
            s3_bad_reg <= s2_bad_reg;
        end
    end

    // stage 4: week flags against the configuration, zero an invalid date
    logic [3:0]    to_end;
    logic [2:0]    dwe;
    logic          wk;
    cdi_pkg::res_t res_next;
    cdi_pkg::res_t res_reg;

    assign to_end = {1'b0, cfg.week_end_day} + 4'd7 - {1'b0, s3_wd_reg};
    assign dwe    = (to_end >= 4'd7) ? 3'(to_end - 4'd7) : to_end[2:0];
    assign wk     = cfg.weekend_mask[s3_wd_reg];

    always_comb begin
        res_next = '0;
        if (s3_bad_reg) begin
            res_next.date_invalid = 1'b1;
        end else begin
            res_next.weekday           = s3_wd_reg;
            res_next.is_week_end_day   = (s3_wd_reg == cfg.week_end_day);
            res_next.is_weekend        = wk;
            res_next.is_business_day   = !wk;
            res_next.days_to_week_end  = dwe;
            res_next.days_to_month_end = s3_dme_reg;
            res_next.days_to_year_end  = s3_dye_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_res   = res_reg;

    `CDI_ASSERT_NOW(a_invalid_zero, aclk, aresetn, v4_reg && res_reg.date_invalid,
        res_reg.days_to_month_end == 5'd0 && res_reg.days_to_year_end == 9'd0
        && res_reg.weekday == 3'd0)
    `CDI_ASSERT_NOW(a_valid_counts, aclk, aresetn, v4_reg && !res_reg.date_invalid,
        res_reg.days_to_month_end != 5'd0 && res_reg.days_to_year_end != 9'd0
        && res_reg.weekday != cdi_pkg::WEEKDAY_INVALID)
    `CDI_ASSERT_NOW(a_week_end, aclk, aresetn, v4_reg && !res_reg.date_invalid,
        (res_reg.days_to_week_end == 3'd0) == res_reg.is_week_end_day
        && res_reg.is_business_day != res_reg.is_weekend)
    `CDI_ASSERT_NEXT(a_stage_hold, aclk, aresetn, v3_reg && !rdy3, v3_reg && v4_reg)

endmodule

FILE: hdl/calendar_date_info.sv
// Gregorian date information: weekday, week flags and days left to week, month and year end.
// Each input transfer passes through the four-stage pipeline, each stage registered, with
// per-stage stall; one transfer per cycle sustained while m_tready stays high.
// Reset (aresetn low, synchronous) empties the pipeline and sets weekend_mask to 48 and
// week_end_day to 6.
// Depends on cdi_pkg and cdi_core.
module calendar_date_info (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // day[4:0], month[8:5], year[22:9], zero[23]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // weekday[2:0], is_week_end_day[3], is_weekend[4],
                                   // is_business_day[5], days_to_week_end[8:6],
                                   // days_to_month_end[13:9], days_to_year_end[22:14],
                                   // date_invalid[23]
    input  logic        cfg_wen,
    input  logic        cfg_addr,
    input  logic [cdi_pkg::CFG_WIDTH-1:0] cfg_wdata
);

    cdi_pkg::cfg_t cfg_reg, cfg_next;
    cdi_pkg::res_t res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wen) begin
            unique case (cfg_addr)
                cdi_pkg::REG_WEEKEND_MASK: cfg_next.weekend_mask = cfg_wdata[6:0];
                cdi_pkg::REG_WEEK_END_DAY: begin
                    if (cfg_wdata[2:0] != cdi_pkg::WEEKDAY_INVALID) begin
                        cfg_next.week_end_day = cfg_wdata[2:0];
                    end
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.weekend_mask <= 7'd48;
            cfg_reg.week_end_day <= 3'd6;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cdi_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_day    (s_tdata[4:0]),
        .in_month  (s_tdata[8:5]),
        .in_year   (s_tdata[22:9]),
        .cfg       (cfg_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = res;

endmodule
